/* hdl/gbpa_pkg.sv */
// Package for the grouped bitmap page allocator: field widths, op and status
// codes, controller states and the find-first-free result type.
// No dependencies; every other file of the block imports it.
package gbpa_pkg;

    // Fixed field widths of the stream payloads.
    localparam int WORD_W     = 64;
    localparam int IDX_W      = 8;
    localparam int PAGE_W     = 14;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 80;

    // The free-bit search works on eight lanes of eight bits each.
    localparam int LANE_W     = 8;
    localparam int LANES      = WORD_W / LANE_W;
    localparam int LANE_POS_W = 3;
    localparam int POS_W      = 6;

    // Default sizing of the allocator.
    localparam int DEF_GROUP_PAGES = 64;
    localparam int DEF_MAX_GROUPS  = 256;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RESTORE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        STATE_IDLE = 2'd0,
        STATE_SCAN = 2'd1,
        STATE_READ = 2'd2,
        STATE_RESP = 2'd3
    } state_t;

    // Outcome of the free-bit search over one group word.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } ffz_result_t;

endpackage

/* hdl/gbpa_bitmap_ram.sv */
// Group bitmap store: one write port and one registered read port.
// Depends on gbpa_pkg for the word width.
module gbpa_bitmap_ram #(
    parameter int DEPTH  = gbpa_pkg::DEF_MAX_GROUPS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [gbpa_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [gbpa_pkg::WORD_W-1:0] rd_data
);
    import gbpa_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    // Synchronous write and read; read data is registered and appears in the cycle after rd_en.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/gbpa_ffz.sv */
// Lowest free page search in one group word, header bit excluded.
// Depends on gbpa_pkg for widths and the result struct.
module gbpa_ffz #(
    parameter int GROUP_PAGES = gbpa_pkg::DEF_GROUP_PAGES
) (
    input  logic [gbpa_pkg::WORD_W-1:0] word,
    output gbpa_pkg::ffz_result_t       result
);
    import gbpa_pkg::*;

    localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - GROUP_PAGES);

    logic [WORD_W-1:0]     free_bits;
    logic [LANES-1:0]      lane_any;
    logic [LANE_POS_W-1:0] lane_pos [LANES];

    // A page is free when its bit is clear; bit 0 is the header page and never free.
    assign free_bits = ~word & WORD_MASK & ~WORD_W'(1);

    // Lowest free bit inside each lane.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_any[l] = |free_bits[l*LANE_W +: LANE_W];
            lane_pos[l] = '0;
            for (int b = LANE_W - 1; b >= 0; b--) begin
                if (free_bits[l*LANE_W + b]) begin
                    lane_pos[l] = LANE_POS_W'(b);
                end
            end
        end
    end

    // Lowest lane that holds a free bit.
    always_comb begin
        result.found = |lane_any;
        result.pos   = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (lane_any[l]) begin
                result.pos = {LANE_POS_W'(l), lane_pos[l]};
            end
        end
    end

endmodule

/* hdl/grouped_bitmap_page_allocator_core.sv */
// Top level of the grouped bitmap page allocator: controller, bitmap store
// and free-bit search. Depends on gbpa_pkg, gbpa_bitmap_ram and gbpa_ffz.
//
// Usage:
//   The s_ channel takes one request per transaction: s_tuser carries the op
//   (allocate, restore group word, read group word), s_tdata carries the
//   group index and the word to restore. The m_ channel returns exactly one
//   result per request: s_tdata-style packing of page_id and read_bits, with
//   the status code in m_tuser.
//   Steps: restore and the unused op pass from acceptance through the result
//   state to the output register, read passes through the read state first,
//   and allocate with a group in use passes through the scan state once for
//   each group visited. The scan reads one group word per cycle through the
//   single read port of the bitmap store.
//   One request is in work at a time; a new one is accepted as soon as the
//   controller is back in idle, even while the previous result still waits
//   in the output register.
//   Reset clears the group count and the controller; the bitmap store is not
//   cleared, since only groups below the count are ever read.
//   When the receiver stalls, the finished result is held in the output
//   register and the next one waits in the controller until it drains.
module grouped_bitmap_page_allocator_core #(
    parameter int GROUP_PAGES = gbpa_pkg::DEF_GROUP_PAGES,
    parameter int MAX_GROUPS  = gbpa_pkg::DEF_MAX_GROUPS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gbpa_pkg::S_TDATA_W-1:0] s_tdata,  // group_index[7:0], group_bits[71:8]
    input  logic [gbpa_pkg::OP_W-1:0]      s_tuser,  // op[1:0]
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gbpa_pkg::M_TDATA_W-1:0] m_tdata,  // page_id[13:0], read_bits[77:14]
    output logic [gbpa_pkg::STAT_W-1:0]    m_tuser   // status[1:0]
);
    import gbpa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
    localparam int ADDR_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CMP_W  = CNT_W + IDX_W;
    localparam int PROD_W = CNT_W + POS_W + PAGE_W;
    localparam int PAD_W  = M_TDATA_W - PAGE_W - WORD_W;
    localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - GROUP_PAGES);

    // Request fields.
    op_t               in_op;
    logic [IDX_W-1:0]  in_idx;
    logic [WORD_W-1:0] in_bits;

    assign in_op   = op_t'(s_tuser);
    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_bits = s_tdata[IDX_W +: WORD_W];

    // Controller state.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   grp_reg, grp_next;
    logic [PAGE_W-1:0]  res_page_reg, res_page_next;
    logic [WORD_W-1:0]  res_bits_reg, res_bits_next;
    status_t            res_status_reg, res_status_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic [PAGE_W-1:0]  m_page_reg;
    logic [WORD_W-1:0]  m_bits_reg;
    status_t            m_status_reg;
    logic               out_load;

    // Bitmap store ports.
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    ffz_result_t        ffz_res;

    gbpa_bitmap_ram #(
        .DEPTH  (MAX_GROUPS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbpa_ffz #(
        .GROUP_PAGES (GROUP_PAGES)
    ) u_ffz (
        .word   (rd_data),
        .result (ffz_res)
    );

    // Index checks against the count of groups in use.
    logic [CMP_W-1:0]  idx_cmp, cnt_cmp;
    logic              idx_in_use, idx_at_end, idx_room, cnt_full;
    logic [CNT_W-1:0]  grp_inc, cnt_inc;
    logic [PROD_W-1:0] append_prod, scan_prod;
    logic              append_req;

    assign idx_cmp    = {{CNT_W{1'b0}}, in_idx};
    assign cnt_cmp    = {{IDX_W{1'b0}}, cnt_reg};
    assign idx_in_use = idx_cmp < cnt_cmp;
    assign idx_at_end = idx_cmp == cnt_cmp;
    assign idx_room   = idx_cmp < CMP_W'(MAX_GROUPS);
    assign cnt_full   = cnt_reg == CNT_W'(MAX_GROUPS);
    assign grp_inc    = grp_reg + CNT_W'(1);
    assign cnt_inc    = cnt_reg + CNT_W'(1);

    // Page numbers: group times pages per group plus position.
    assign append_prod = PROD_W'(cnt_reg) * PROD_W'(GROUP_PAGES) + PROD_W'(1);
    assign scan_prod   = PROD_W'(grp_reg) * PROD_W'(GROUP_PAGES) + PROD_W'(ffz_res.pos);

    // Next state, store accesses and result.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        grp_next        = grp_reg;
        res_page_next   = res_page_reg;
        res_bits_next   = res_bits_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        out_load        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = grp_reg[ADDR_W-1:0];
        wr_data         = rd_data | (WORD_W'(1) << ffz_res.pos);
        rd_en           = 1'b0;
        rd_addr         = grp_inc[ADDR_W-1:0];
        append_req      = 1'b0;
        s_tready        = (state_reg == STATE_IDLE);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            STATE_IDLE: begin
                if (s_tvalid) begin
                    res_page_next   = '0;
                    res_bits_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = STATE_RESP;
                    unique case (in_op)
                        OP_ALLOC: begin
                            if (cnt_reg == '0) begin
                                append_req = 1'b1;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                grp_next   = '0;
                                state_next = STATE_SCAN;
                            end
                        end
                        OP_RESTORE: begin
                            if (idx_in_use) begin
                                wr_en   = 1'b1;
                                wr_addr = idx_cmp[ADDR_W-1:0];
                                wr_data = in_bits & WORD_MASK;
                            end else if (idx_at_end) begin
                                if (!idx_room) begin
                                    res_status_next = ST_FULL;
                                end else begin
                                    wr_en    = 1'b1;
                                    wr_addr  = idx_cmp[ADDR_W-1:0];
                                    wr_data  = in_bits & WORD_MASK;
                                    cnt_next = cnt_inc;
                                end
                            end else begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        OP_READ: begin
                            if (idx_in_use) begin
                                rd_en      = 1'b1;
                                rd_addr    = idx_cmp[ADDR_W-1:0];
                                state_next = STATE_READ;
                            end else begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        default: begin
                            // Unused op answers all fields zero.
                        end
                    endcase
                end
            end
            STATE_SCAN: begin
                // Word of group grp_reg is on rd_data this cycle.
                if (ffz_res.found) begin
                    wr_en         = 1'b1;
                    res_page_next = scan_prod[PAGE_W-1:0];
                    state_next    = STATE_RESP;
                end else if (grp_inc == cnt_reg) begin
                    append_req = 1'b1;
                end else begin
                    rd_en    = 1'b1;
                    grp_next = grp_inc;
                end
            end
            STATE_READ: begin
                res_bits_next = rd_data & WORD_MASK;
                state_next    = STATE_RESP;
            end
            STATE_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = STATE_IDLE;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase

        // No free page: new group with header and first page taken, else ST_FULL.
        if (append_req) begin
            state_next = STATE_RESP;
            if (cnt_full) begin
                res_status_next = ST_FULL;
                res_page_next   = '0;
            end else begin
                wr_en           = 1'b1;
                wr_addr         = cnt_reg[ADDR_W-1:0];
                wr_data         = WORD_W'(3);
                cnt_next        = cnt_inc;
                res_page_next   = append_prod[PAGE_W-1:0];
                res_status_next = ST_OK;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_IDLE;
            cnt_reg     <= '0;
            grp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            grp_reg     <= grp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result and output payload registers.
    always_ff @(posedge aclk) begin
        res_page_reg   <= res_page_next;
        res_bits_reg   <= res_bits_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_page_reg   <= res_page_reg;
            m_bits_reg   <= res_bits_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_bits_reg, m_page_reg};
    assign m_tuser  = m_status_reg;

    // The group count never passes the number of groups.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_GROUPS))
        else $error("group count beyond the number of groups");

    // The scan only visits groups in use.
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == STATE_SCAN) |-> (grp_reg < cnt_reg))
        else $error("scan visits a group that is not in use");

    // The group count only ever grows by one.
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (cnt_reg != $past(cnt_reg)))
            |-> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("group count changed by more than one");

    // A new result appears only after the controller held one ready.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == STATE_RESP))
        else $error("output loaded without a finished result");

endmodule

/* dv/grouped_bitmap_page_allocator_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for grouped_bitmap_page_allocator_core: a queue-fed request
// driver, a result monitor and a predictor that tracks the group bitmaps and group count.
// Depends on gbpa_pkg and the allocator RTL only.
module grouped_bitmap_page_allocator_core_tb;
    import gbpa_pkg::*;

    localparam int GROUP_PAGES = DEF_GROUP_PAGES;
    localparam int MAX_GROUPS  = DEF_MAX_GROUPS;
    localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - GROUP_PAGES);
    localparam int HOLD_CYCLES = 120;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        op_t              op;
        logic [IDX_W-1:0] group_index;
        logic [WORD_W-1:0] group_bits;
    } page_request_t;

    typedef struct {
        logic [PAGE_W-1:0] page_id;
        logic [WORD_W-1:0] read_bits;
        status_t           status;
    } page_reply_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // Requests waiting to be offered, and replies predicted for accepted requests.
    page_request_t pending_requests[$];
    page_reply_t   expected_replies[$];
    page_request_t offered_request;

    // Predicted allocator state.
    logic [WORD_W-1:0] bitmap_mirror [MAX_GROUPS];
    int                groups_used = 0;

    // Stimulus bookkeeping: group count as the generator sees it.
    int next_group = 0;
    int send_idle  = 28;
    int recv_idle  = 46;
    logic hold_req = 1'b0;
    int hold_cnt   = 0;
    int unsigned fail_count = 0;

    grouped_bitmap_page_allocator_core #(
        .GROUP_PAGES (GROUP_PAGES),
        .MAX_GROUPS  (MAX_GROUPS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply one accepted request to the predicted state and queue its reply.
    task automatic predict_request(page_request_t req);
        page_reply_t reply;
        bit          found;
        int          idx;
        reply = '{page_id: '0, read_bits: '0, status: ST_OK};
        found = 1'b0;
        idx   = req.group_index;
        case (req.op)
            OP_ALLOC: begin
                // First fit: lowest clear bit at position 1 or above, group by group.
                for (int g = 0; g < groups_used && !found; g++) begin
                    for (int p = 1; p < GROUP_PAGES && !found; p++) begin
                        if (!bitmap_mirror[g][p]) begin
                            bitmap_mirror[g][p] = 1'b1;
                            reply.page_id = PAGE_W'(g * GROUP_PAGES + p);
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    if (groups_used >= MAX_GROUPS) begin
                        reply.status = ST_FULL;
                    end else begin
                        bitmap_mirror[groups_used] = 'h3;
                        reply.page_id = PAGE_W'(groups_used * GROUP_PAGES + 1);
                        groups_used++;
                    end
                end
            end
            OP_RESTORE: begin
                if (idx < groups_used) begin
                    bitmap_mirror[idx] = req.group_bits & WORD_MASK;
                end else if (idx == groups_used) begin
                    if (idx >= MAX_GROUPS) begin
                        reply.status = ST_FULL;
                    end else begin
                        bitmap_mirror[idx] = req.group_bits & WORD_MASK;
                        groups_used++;
                    end
                end else begin
                    reply.status = ST_RANGE;
                end
            end
            OP_READ: begin
                if (idx < groups_used) begin
                    reply.read_bits = bitmap_mirror[idx] & WORD_MASK;
                end else begin
                    reply.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        expected_replies.insert(expected_replies.size(), reply);
    endtask

    // Request driver: a new transaction is offered once the previous one is taken.
    always @(posedge aclk) begin : request_driver
        page_request_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request(offered_request);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_req = pending_requests.pop_front();
                    offered_request <= next_req;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_req.group_bits, next_req.group_index};
                    s_tuser  <= next_req.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls, plus one long hold-off to back the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result monitor: compare each transaction against the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        page_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("unexpected result: page_id %0d read_bits %h status %0d",
                             m_tdata[PAGE_W-1:0], m_tdata[PAGE_W +: WORD_W], m_tuser);
                end
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[PAGE_W-1:0] !== want.page_id ||
                    m_tdata[PAGE_W +: WORD_W] !== want.read_bits ||
                    m_tuser !== want.status) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch: page_id exp %0d got %0d, bits exp %h got %h",
                                 want.page_id, m_tdata[PAGE_W-1:0],
                                 want.read_bits, m_tdata[PAGE_W +: WORD_W]);
                        $display("          status exp %0d got %0d",
                                 want.status, m_tuser);
                    end
                end
            end
        end
    end

    task automatic queue_request(op_t op, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] bits);
        page_request_t req;
        req.op          = op;
        req.group_index = idx;
        req.group_bits  = bits;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // Bitmap words from empty to packed, with the header-only-free case among them.
    function automatic logic [WORD_W-1:0] random_group_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(5))
            0: w = '1;
            1: w = ~(64'd1 << $urandom_range(WORD_W - 1));
            2: w = '0;
            3: w = ~64'd1;
            4: w = {$urandom, $urandom};
            default: w = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_bits64();
        return {$urandom, $urandom};
    endfunction

    // Pick a group index that is in use, if any group is.
    function automatic logic [IDX_W-1:0] used_group();
        if (next_group == 0) begin
            return '0;
        end
        return IDX_W'($urandom_range(next_group - 1));
    endfunction

    // General mix of allocate, restore, read and the unused op.
    task automatic queue_random_mix(int count);
        int r;
        int s;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                queue_request(OP_ALLOC, IDX_W'($urandom), random_bits64());
            end else if (r < 70) begin
                s = $urandom_range(9);
                if (s < 6 && next_group < MAX_GROUPS) begin
                    queue_request(OP_RESTORE, IDX_W'(next_group), random_group_word());
                    next_group++;
                end else if (s < 9) begin
                    queue_request(OP_RESTORE, used_group(), random_group_word());
                end else begin
                    queue_request(OP_RESTORE, IDX_W'($urandom), random_group_word());
                end
            end else if (r < 95) begin
                if ($urandom_range(4) != 0) begin
                    queue_request(OP_READ, used_group(), random_bits64());
                end else begin
                    queue_request(OP_READ, IDX_W'($urandom), random_bits64());
                end
            end else begin
                queue_request(OP_NONE, IDX_W'($urandom), random_bits64());
            end
        end
    endtask

    // Append mostly packed groups until every group slot is taken.
    task automatic queue_fill_groups();
        int r;
        logic [WORD_W-1:0] w;
        while (next_group < MAX_GROUPS) begin
            r = $urandom_range(9);
            if (r < 8) begin
                case ($urandom_range(9))
                    0, 1:    w = ~64'd1;
                    2:       w = random_group_word();
                    default: w = '1;
                endcase
                queue_request(OP_RESTORE, IDX_W'(next_group), w);
                next_group++;
            end else if (r == 8) begin
                queue_request(OP_READ, used_group(), random_bits64());
            end else begin
                queue_request(OP_ALLOC, IDX_W'($urandom), random_bits64());
            end
        end
    endtask

    // Wait until every queued request was taken and every reply came back.
    // Sampled at the falling edge, after the driver's updates have settled.
    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0);
    endtask

    // Main sequence.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks while no group is in use, then around the first groups.
        queue_request(OP_READ,    8'd0,   '0);                        // read with no groups
        queue_request(OP_RESTORE, 8'd1,   '1);                        // restore beyond the end
        queue_request(OP_NONE,    8'd255, '1);                        // unused op
        queue_request(OP_ALLOC,   8'd255, '1);                        // appends group 0
        queue_request(OP_ALLOC,   8'd0,   '0);
        queue_request(OP_READ,    8'd0,   '0);
        queue_request(OP_RESTORE, 8'd0,   64'hFFFF_FFFF_FFFF_FFFE);   // only header bit clear
        queue_request(OP_ALLOC,   8'd0,   '0);                        // skips group 0
        queue_request(OP_READ,    8'd0,   '0);
        queue_request(OP_RESTORE, 8'd2,   '0);                        // restore at the end
        queue_request(OP_ALLOC,   8'd0,   '0);
        queue_request(OP_RESTORE, 8'd1,   '1);
        queue_request(OP_ALLOC,   8'd0,   '0);
        queue_request(OP_READ,    8'd2,   '0);
        queue_request(OP_RESTORE, 8'd3,   64'h7FFF_FFFF_FFFF_FFFF);   // top page free
        queue_request(OP_RESTORE, 8'd2,   '1);
        queue_request(OP_ALLOC,   8'd0,   '0);
        queue_request(OP_READ,    8'd3,   '0);
        queue_request(OP_READ,    8'd4,   '0);                        // read at the end
        queue_request(OP_RESTORE, 8'd5,   64'h5555_5555_5555_5555);
        queue_request(OP_READ,    8'd255, '0);
        queue_request(OP_RESTORE, 8'd4,   64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(OP_ALLOC,   8'd0,   '0);
        wait_for_drain();

        // Random mix, sender and receiver both idling.
        next_group = groups_used;
        queue_random_mix(70);
        wait_for_drain();

        // Idling swapped; fill every group slot.
        send_idle <= 46;
        recv_idle <= 28;
        next_group = groups_used;
        queue_fill_groups();
        wait_for_drain();

        // No idling. The receiver first holds off while requests keep coming.
        send_idle <= 0;
        recv_idle <= 0;
        hold_req  <= 1'b1;
        next_group = groups_used;
        for (int g = 0; g < groups_used; g++) begin
            if (((bitmap_mirror[g] | 64'd1) & WORD_MASK) != WORD_MASK) begin
                queue_request(OP_RESTORE, IDX_W'(g), '1);
            end
        end
        queue_request(OP_ALLOC,   8'd0,   '0);                        // no room for a new group
        queue_request(OP_ALLOC,   8'd0,   '0);
        queue_request(OP_RESTORE, 8'd17,  ~(64'd1 << 40));
        queue_request(OP_ALLOC,   8'd0,   '0);
        queue_request(OP_RESTORE, 8'd200, ~64'd1);
        queue_request(OP_ALLOC,   8'd0,   '0);
        queue_request(OP_READ,    8'd255, '0);
        queue_random_mix(30);
        wait_for_drain();

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && expected_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/gbpa_pkg.sv
hdl/gbpa_bitmap_ram.sv
hdl/gbpa_ffz.sv
hdl/grouped_bitmap_page_allocator_core.sv
dv/grouped_bitmap_page_allocator_core_tb.sv
